// File: hdl/hsvrgb_pkg.sv
// Shared constants and types of the HSV to RGB converter.
package hsvrgb_pkg;

  // Default component width (saturation, value and colour outputs)
  localparam int COMPONENT_BITS_DEF = 16;

  // Hue coding: 1/64 degree, one full turn is 360 degrees
  localparam int          HUE_BITS      = 15;
  localparam int unsigned HUE_FULL_TURN = 23040;
  localparam int unsigned HUE_SECTOR    = 3840;

  // Remainder within a sector is below HUE_SECTOR
  localparam int REM_BITS    = 12;
  localparam int SECTOR_BITS = 3;

  // Sector width factors as an odd part times a power of two: 3840 = 15 << 8
  localparam int DIV_SHIFT = 8;
  localparam int DIV_ODD   = 15;

  // Lanes of the shared p/q/t datapath
  localparam int NLANE  = 3;
  localparam int LANE_P = 0;
  localparam int LANE_Q = 1;
  localparam int LANE_T = 2;

  // Sixty-degree sector of the colour wheel
  typedef enum logic [SECTOR_BITS-1:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

endpackage

// File: hdl/hsvrgb_if.sv
// Valid/ready channel interfaces for HSV requests and RGB results.
interface hsvrgb_in_if #(
  parameter int COMPONENT_BITS = hsvrgb_pkg::COMPONENT_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [hsvrgb_pkg::HUE_BITS-1:0] hue;
  logic [COMPONENT_BITS-1:0]       saturation;
  logic [COMPONENT_BITS-1:0]       brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvrgb_out_if #(
  parameter int COMPONENT_BITS = hsvrgb_pkg::COMPONENT_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red;
  logic [COMPONENT_BITS-1:0] green;
  logic [COMPONENT_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: hdl/hsv_to_rgb_converter_unit.sv
// HSV to RGB converter: nine-stage pipeline with p, q and t lanes.
//
// Usage:
//   in_ch  carries one HSV colour per request: hue in 1/64 degree (23040 and
//          above read as zero), saturation and brightness as unsigned
//          fractions in which all ones stands for 1.0.
//   out_ch carries one RGB colour per request, components of the same width.
// Both channels move a request at a clock edge with valid and ready high.
// Path: a request taken on in_ch passes through every stage register in order
//   and then shows on out_ch, where it leaves with valid and ready high.
// Throughput: one request per cycle while out_ch is ready; every stage holds one
//   request and the stage multipliers (S*k, V*T in two halves, the
//   reciprocal of 15) each take a stage of their own.
// Stall: each stage has its own valid bit and advances when the stage after
//   it is empty or moving, so bubbles close up and in_ch stays ready while
//   any stage is free, also while a result waits on out_ch.
// Reset (rst_n low, synchronous) empties all stages; no result is lost or
//   repeated across a stall.
module hsv_to_rgb_converter_unit #(
  parameter int COMPONENT_BITS = hsvrgb_pkg::COMPONENT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  hsvrgb_in_if.sink    in_ch,
  hsvrgb_out_if.source out_ch
);

  localparam int N     = COMPONENT_BITS;
  localparam int HW    = hsvrgb_pkg::HUE_BITS;
  localparam int RW    = hsvrgb_pkg::REM_BITS;
  localparam int NL    = hsvrgb_pkg::NLANE;
  localparam int NSTG  = 9;
  // Widths of the lane datapath
  localparam int TW    = N + RW;          // T = M*D - S*k
  localparam int TLW   = TW / 2;
  localparam int THW   = TW - TLW;
  localparam int XW    = 2 * N + RW;      // V*T
  localparam int FW    = N + RW + 1;      // folded remainder
  localparam int UW    = N + RW;          // floor(V*T / M)
  localparam int L     = UW - hsvrgb_pkg::DIV_SHIFT;
  localparam int OB    = $clog2(hsvrgb_pkg::DIV_ODD + 1);
  localparam int CW    = L + 1;
  localparam int PW    = L + CW;

  localparam logic [N-1:0]  M      = {N{1'b1}};
  localparam logic [N:0]    M2     = {M, 1'b0};
  localparam logic [63:0]   MD64   = ((64'd1 << N) - 64'd1) * 64'(hsvrgb_pkg::HUE_SECTOR);
  localparam logic [TW-1:0] MD     = MD64[TW-1:0];
  localparam logic [RW-1:0] DSEC   = RW'(hsvrgb_pkg::HUE_SECTOR);
  localparam logic [63:0]   RECIP64 =
    ((64'd1 << (L + OB)) + 64'(hsvrgb_pkg::DIV_ODD - 1)) / 64'(hsvrgb_pkg::DIV_ODD);
  localparam logic [CW-1:0] RECIP  = RECIP64[CW-1:0];

  // Stage control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] stg_en;

  // Side data carried along every stage but the output stage
  hsvrgb_pkg::sector_t sec_r [NSTG-1];
  logic [N-1:0]        val_r [NSTG-1];

  // Stage payloads
  logic [RW-1:0]    rem1_r;
  logic [N-1:0]     sat1_r;
  logic [TW-1:0]    t2_r    [NL];
  logic [N+TLW-1:0] pplo3_r [NL];
  logic [N+THW-1:0] pphi3_r [NL];
  logic [XW-1:0]    x4_r    [NL];
  logic [UW-1:0]    acc5_r  [NL];
  logic [FW-1:0]    w5_r    [NL];
  logic [UW-1:0]    acc6_r  [NL];
  logic [N:0]       w6_r    [NL];
  logic [UW-1:0]    u7_r    [NL];
  logic [PW-1:0]    m8_r    [NL];
  logic [N-1:0]     red_r, green_r, blue_r;

  // Next values
  hsvrgb_pkg::sector_t sec1_nxt;
  logic [RW-1:0]    rem1_nxt;
  logic [TW-1:0]    t2_nxt    [NL];
  logic [N+TLW-1:0] pplo3_nxt [NL];
  logic [N+THW-1:0] pphi3_nxt [NL];
  logic [XW-1:0]    x4_nxt    [NL];
  logic [UW-1:0]    acc5_nxt  [NL];
  logic [FW-1:0]    w5_nxt    [NL];
  logic [UW-1:0]    acc6_nxt  [NL];
  logic [N:0]       w6_nxt    [NL];
  logic [UW-1:0]    u7_nxt    [NL];
  logic [PW-1:0]    m8_nxt    [NL];
  logic [N-1:0]     comp9     [NL];
  logic [N-1:0]     red_nxt, green_nxt, blue_nxt;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    stg_en[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      stg_en[i] = !vld_r[i] || stg_en[i+1];
    end
  end

  assign in_ch.ready  = stg_en[0];
  assign out_ch.valid = vld_r[NSTG-1];
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

  // Move valid bits, drop bubbles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (stg_en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Stage 1: wrap the hue, split into sector and remainder
  always_comb begin
    logic [HW-1:0] hue_w;
    logic [HW-1:0] base;
    hue_w = (in_ch.hue >= HW'(hsvrgb_pkg::HUE_FULL_TURN)) ? '0 : in_ch.hue;
    priority if (hue_w >= HW'(5 * hsvrgb_pkg::HUE_SECTOR)) begin
      sec1_nxt = hsvrgb_pkg::SEC_5;
      base     = HW'(5 * hsvrgb_pkg::HUE_SECTOR);
    end else if (hue_w >= HW'(4 * hsvrgb_pkg::HUE_SECTOR)) begin
      sec1_nxt = hsvrgb_pkg::SEC_4;
      base     = HW'(4 * hsvrgb_pkg::HUE_SECTOR);
    end else if (hue_w >= HW'(3 * hsvrgb_pkg::HUE_SECTOR)) begin
      sec1_nxt = hsvrgb_pkg::SEC_3;
      base     = HW'(3 * hsvrgb_pkg::HUE_SECTOR);
    end else if (hue_w >= HW'(2 * hsvrgb_pkg::HUE_SECTOR)) begin
      sec1_nxt = hsvrgb_pkg::SEC_2;
      base     = HW'(2 * hsvrgb_pkg::HUE_SECTOR);
    end else if (hue_w >= HW'(hsvrgb_pkg::HUE_SECTOR)) begin
      sec1_nxt = hsvrgb_pkg::SEC_1;
      base     = HW'(hsvrgb_pkg::HUE_SECTOR);
    end else begin
      sec1_nxt = hsvrgb_pkg::SEC_0;
      base     = '0;
    end
    rem1_nxt = RW'(hue_w - base);
  end

  // Stage 2: T = M*D - S*k with k = D (p), r (q), D - r (t)
  always_comb begin
    logic [RW-1:0] k [NL];
    k[hsvrgb_pkg::LANE_P] = DSEC;
    k[hsvrgb_pkg::LANE_Q] = rem1_r;
    k[hsvrgb_pkg::LANE_T] = DSEC - rem1_r;
    for (int l = 0; l < NL; l++) begin
      t2_nxt[l] = MD - (TW'(sat1_r) * TW'(k[l]));
    end
  end

  // Stage 3: V*T as two partial products
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      pplo3_nxt[l] = (N+TLW)'(val_r[1]) * (N+TLW)'(t2_r[l][TLW-1:0]);
      pphi3_nxt[l] = (N+THW)'(val_r[1]) * (N+THW)'(t2_r[l][TW-1:TLW]);
    end
  end

  // Stage 4: join the partial products
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      x4_nxt[l] = (XW'(pphi3_r[l]) << TLW) + XW'(pplo3_r[l]);
    end
  end

  // Stage 5: first fold of the division by M = 2^N - 1
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      acc5_nxt[l] = x4_r[l][XW-1:N];
      w5_nxt[l]   = FW'(x4_r[l][XW-1:N]) + FW'(x4_r[l][N-1:0]);
    end
  end

  // Stage 6: two more folds bring the remainder to at most 2M
  always_comb begin
    logic [FW-1:0] w2;
    logic [FW-1:0] w3;
    for (int l = 0; l < NL; l++) begin
      w2          = FW'(w5_r[l][FW-1:N]) + FW'(w5_r[l][N-1:0]);
      w3          = FW'(w2[FW-1:N]) + FW'(w2[N-1:0]);
      acc6_nxt[l] = acc5_r[l] + UW'(w5_r[l][FW-1:N]) + UW'(w2[FW-1:N]);
      w6_nxt[l]   = w3[N:0];
    end
  end

  // Stage 7: final correction of the quotient by M
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      u7_nxt[l] = acc6_r[l] + UW'(w6_r[l] >= {1'b0, M}) + UW'(w6_r[l] >= M2);
    end
  end

  // Stage 8: divide by D: shift out the power of two, multiply by 1/15
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      m8_nxt[l] = PW'(u7_r[l][UW-1:hsvrgb_pkg::DIV_SHIFT]) * PW'(RECIP);
    end
  end

  // Stage 9: saturate and order the components by sector
  always_comb begin
    logic [N:0] quo;
    for (int l = 0; l < NL; l++) begin
      quo      = m8_r[l][L+OB +: N+1];
      comp9[l] = (quo > {1'b0, M}) ? M : quo[N-1:0];
    end
    unique case (sec_r[NSTG-2])
      hsvrgb_pkg::SEC_0: begin
        red_nxt   = val_r[NSTG-2];
        green_nxt = comp9[hsvrgb_pkg::LANE_T];
        blue_nxt  = comp9[hsvrgb_pkg::LANE_P];
      end
      hsvrgb_pkg::SEC_1: begin
        red_nxt   = comp9[hsvrgb_pkg::LANE_Q];
        green_nxt = val_r[NSTG-2];
        blue_nxt  = comp9[hsvrgb_pkg::LANE_P];
      end
      hsvrgb_pkg::SEC_2: begin
        red_nxt   = comp9[hsvrgb_pkg::LANE_P];
        green_nxt = val_r[NSTG-2];
        blue_nxt  = comp9[hsvrgb_pkg::LANE_T];
      end
      hsvrgb_pkg::SEC_3: begin
        red_nxt   = comp9[hsvrgb_pkg::LANE_P];
        green_nxt = comp9[hsvrgb_pkg::LANE_Q];
        blue_nxt  = val_r[NSTG-2];
      end
      hsvrgb_pkg::SEC_4: begin
        red_nxt   = comp9[hsvrgb_pkg::LANE_T];
        green_nxt = comp9[hsvrgb_pkg::LANE_P];
        blue_nxt  = val_r[NSTG-2];
      end
      // last sector, and codes that never occur
      default: begin
        red_nxt   = val_r[NSTG-2];
        green_nxt = comp9[hsvrgb_pkg::LANE_P];
        blue_nxt  = comp9[hsvrgb_pkg::LANE_Q];
      end
    endcase
  end

  // Load payloads on advance, hold otherwise
  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      sec_r[0] <= sec1_nxt;
      val_r[0] <= in_ch.brightness;
      rem1_r   <= rem1_nxt;
      sat1_r   <= in_ch.saturation;
    end
    for (int i = 1; i < NSTG - 1; i++) begin
      if (stg_en[i]) begin
        sec_r[i] <= sec_r[i-1];
        val_r[i] <= val_r[i-1];
      end
    end
    for (int l = 0; l < NL; l++) begin
      if (stg_en[1]) t2_r[l] <= t2_nxt[l];
      if (stg_en[2]) begin
        pplo3_r[l] <= pplo3_nxt[l];
        pphi3_r[l] <= pphi3_nxt[l];
      end
      if (stg_en[3]) x4_r[l] <= x4_nxt[l];
      if (stg_en[4]) begin
        acc5_r[l] <= acc5_nxt[l];
        w5_r[l]   <= w5_nxt[l];
      end
      if (stg_en[5]) begin
        acc6_r[l] <= acc6_nxt[l];
        w6_r[l]   <= w6_nxt[l];
      end
      if (stg_en[6]) u7_r[l] <= u7_nxt[l];
      if (stg_en[7]) m8_r[l] <= m8_nxt[l];
    end
    if (stg_en[NSTG-1]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  // A full pipeline under a stalled receiver takes no request
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("request taken while every stage is full and stalled");

  // Remainder within a sector stays below the sector width
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (rem1_r < DSEC))
    else $error("hue remainder out of range");

  // Folding leaves a remainder of at most 2M in every lane
  a_fold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (w6_r[hsvrgb_pkg::LANE_P] <= M2 && w6_r[hsvrgb_pkg::LANE_Q] <= M2 &&
                  w6_r[hsvrgb_pkg::LANE_T] <= M2))
    else $error("fold remainder exceeds 2M");

  // p is never above q or t
  a_p_lowest: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] |-> (u7_r[hsvrgb_pkg::LANE_P] <= u7_r[hsvrgb_pkg::LANE_Q] &&
                  u7_r[hsvrgb_pkg::LANE_P] <= u7_r[hsvrgb_pkg::LANE_T]))
    else $error("p lane above q or t lane");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule
